// ===== design/dtp_pkg.sv =====
package dtp_pkg;

  // Length field limits
  localparam int unsigned MaxLenBytesDef = 4;
  localparam int unsigned LenW           = 32;
  localparam int unsigned HdrW           = 3;

  localparam logic [7:0]      TagRsvLow     = 8'h00;
  localparam logic [7:0]      TagRsvHigh    = 8'hFF;
  localparam logic [6:0]      LongCountMask = 7'h7F;
  localparam logic [LenW-1:0] LenSat        = 32'hFFFF_FFFF;
  localparam logic [LenW-1:0] LenShiftLimit = 32'h00FF_FFFF;
  localparam logic [HdrW-1:0] HdrMax        = 3'd7;

  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_LEN   = 2'd1,
    PH_LONG  = 2'd2,
    PH_VALUE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_TAG     = 2'd0,
    ROLE_LEN     = 2'd1,
    ROLE_VALUE   = 2'd2,
    ROLE_IGNORED = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_OK     = 3'd1,
    ST_BADLEN = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_RSVTAG = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       body_last;
  } in_item_t;

  typedef struct packed {
    role_e           byte_role;
    logic [7:0]      elem_tag;
    logic [LenW-1:0] value_length;
    logic [HdrW-1:0] header_bytes;
    logic            element_end;
    status_e         status;
    logic            body_end;
  } out_item_t;

  // Handoff control between the input stage and the result stage
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

endpackage

// ===== design/dtp_stream_if.sv =====
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       body_last;

  modport source (output valid, output data_byte, output body_last, input ready);
  modport sink   (input valid, input data_byte, input body_last, output ready);
endinterface

interface dtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic [7:0]  elem_tag;
  logic [31:0] value_length;
  logic [2:0]  header_bytes;
  logic        element_end;
  logic [2:0]  status;
  logic        body_end;

  modport source (output valid, output byte_role, output elem_tag, output value_length,
                  output header_bytes, output element_end, output status,
                  output body_end, input ready);
  modport sink   (input valid, input byte_role, input elem_tag, input value_length,
                  input header_bytes, input element_end, input status,
                  input body_end, output ready);
endinterface

// ===== design/dtp_in_reg.sv =====
module dtp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  dtp_in_if.sink             in_i,
  input  logic               advance_i,
  output dtp_pkg::in_item_t  item_o,
  output logic               valid_o
);

  logic              valid_q;
  dtp_pkg::in_item_t item_q;
  logic              take;

  // Accept a request whenever the slot is free or drains this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.body_last <= in_i.body_last;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

// ===== design/dtp_step.sv =====
module dtp_step #(
  parameter int unsigned MaxLenBytes = dtp_pkg::MaxLenBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  dtp_pkg::in_item_t   item_i,
  output dtp_pkg::out_item_t  res_o
);

  localparam int unsigned LeftW = $clog2(MaxLenBytes + 1);
  localparam int unsigned LenW  = dtp_pkg::LenW;
  localparam int unsigned HdrW  = dtp_pkg::HdrW;

  dtp_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       tag_q, tag_d;
  logic [LenW-1:0]  accum_q, accum_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [LenW-1:0]  vleft_q, vleft_d;
  logic [HdrW-1:0]  hdr_q, hdr_d;
  logic             halted_q, halted_d;

  logic [7:0]       b;
  logic [6:0]       count;
  logic [LeftW-1:0] left_dec;
  logic [LenW-1:0]  vleft_dec;
  logic [HdrW-1:0]  hdr_inc;
  logic             done;
  dtp_pkg::status_e status;
  dtp_pkg::role_e   role;
  logic [LenW-1:0]  vlen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dtp_pkg::PH_TAG;
    end else if (fire_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q    <= '0;
      accum_q  <= '0;
      left_q   <= '0;
      vleft_q  <= '0;
      hdr_q    <= '0;
      halted_q <= 1'b0;
    end else if (fire_i) begin
      tag_q    <= tag_d;
      accum_q  <= accum_d;
      left_q   <= left_d;
      vleft_q  <= vleft_d;
      hdr_q    <= hdr_d;
      halted_q <= halted_d;
    end
  end

  assign b         = item_i.data_byte;
  assign count     = b[6:0] & dtp_pkg::LongCountMask;
  assign left_dec  = (left_q != '0) ? left_q - LeftW'(1) : left_q;
  assign vleft_dec = (vleft_q != '0) ? vleft_q - LenW'(1) : vleft_q;
  assign hdr_inc   = (hdr_q < dtp_pkg::HdrMax) ? hdr_q + HdrW'(1) : hdr_q;

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    accum_d  = accum_q;
    left_d   = left_q;
    vleft_d  = vleft_q;
    hdr_d    = hdr_q;
    halted_d = halted_q;
    done     = 1'b0;
    status   = dtp_pkg::ST_BUSY;
    role     = dtp_pkg::ROLE_IGNORED;
    vlen     = '0;

    res_o = '0;

    if (!halted_q) begin
      unique case (phase_q)
        dtp_pkg::PH_LEN: begin
          role  = dtp_pkg::ROLE_LEN;
          hdr_d = hdr_inc;
          if (b[7]) begin
            if (count == 7'd0 || count > 7'(MaxLenBytes)) begin
              status = dtp_pkg::ST_BADLEN;
            end else begin
              left_d  = count[LeftW-1:0];
              accum_d = '0;
              phase_d = dtp_pkg::PH_LONG;
            end
          end else begin
            accum_d = LenW'(b);
            vlen    = LenW'(b);
            vleft_d = LenW'(b);
            if (b == 8'd0) begin
              done = 1'b1;
            end else begin
              phase_d = dtp_pkg::PH_VALUE;
            end
          end
        end
        dtp_pkg::PH_LONG: begin
          role  = dtp_pkg::ROLE_LEN;
          hdr_d = hdr_inc;
          // Saturate once another shift would push bits out of the top
          if (accum_q > dtp_pkg::LenShiftLimit) begin
            accum_d = dtp_pkg::LenSat;
          end else begin
            accum_d = {accum_q[LenW-9:0], b};
          end
          left_d = left_dec;
          if (left_dec == '0) begin
            vlen    = accum_d;
            vleft_d = accum_d;
            if (accum_d == '0) begin
              done = 1'b1;
            end else begin
              phase_d = dtp_pkg::PH_VALUE;
            end
          end
        end
        dtp_pkg::PH_VALUE: begin
          role    = dtp_pkg::ROLE_VALUE;
          vlen    = accum_q;
          vleft_d = vleft_dec;
          if (vleft_dec == '0) begin
            done = 1'b1;
          end
        end
        dtp_pkg::PH_TAG: begin
          role    = dtp_pkg::ROLE_TAG;
          tag_d   = b;
          hdr_d   = HdrW'(1);
          accum_d = '0;
          left_d  = '0;
          vleft_d = '0;
          phase_d = dtp_pkg::PH_LEN;
        end
        default: begin
          phase_d = dtp_pkg::PH_TAG;
        end
      endcase

      if (done) begin
        status = (tag_d == dtp_pkg::TagRsvLow || tag_d == dtp_pkg::TagRsvHigh)
                 ? dtp_pkg::ST_RSVTAG : dtp_pkg::ST_OK;
      end else if (status == dtp_pkg::ST_BUSY && item_i.body_last) begin
        status = dtp_pkg::ST_TRUNC;
      end

      if (status != dtp_pkg::ST_BUSY) begin
        phase_d = dtp_pkg::PH_TAG;
        if (status != dtp_pkg::ST_OK) begin
          halted_d = 1'b1;
        end
      end

      res_o.elem_tag     = tag_d;
      res_o.header_bytes = hdr_d;
    end

    // End of body: restart cleanly on the next one
    if (item_i.body_last) begin
      halted_d = 1'b0;
      phase_d  = dtp_pkg::PH_TAG;
    end

    res_o.byte_role    = role;
    res_o.value_length = vlen;
    res_o.element_end  = (status != dtp_pkg::ST_BUSY);
    res_o.status       = status;
    res_o.body_end     = item_i.body_last;
  end

endmodule

// ===== design/dtp_out_reg.sv =====
module dtp_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtp_pkg::stage_ctrl_t ctrl_i,
  input  dtp_pkg::out_item_t   res_i,
  output logic                 can_load_o,
  dtp_out_if.source            out_o
);

  logic               valid_q;
  dtp_pkg::out_item_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= ctrl_i.valid && ctrl_i.advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.byte_role    = res_q.byte_role;
  assign out_o.elem_tag     = res_q.elem_tag;
  assign out_o.value_length = res_q.value_length;
  assign out_o.header_bytes = res_q.header_bytes;
  assign out_o.element_end  = res_q.element_end;
  assign out_o.status       = res_q.status;
  assign out_o.body_end     = res_q.body_end;

endmodule

// ===== design/der_tlv_stream_parser.sv =====
// DER tag-length-value splitter, one body byte per request.
// in_i carries data_byte and body_last (set on the final byte of a body).
// out_o returns exactly one result per byte: its role (tag, length, value,
// or ignored after an error), the element tag, the declared value length,
// the header byte count, an element-end flag with status, and an echo of
// body_last.
// A byte accepted on in_i is held in the input register, passes through the
// parse step logic and is loaded into the result register, which drives out_o.
// Throughput: one byte per cycle while out_o is not stalled; the header/length
// state update is a few compares, one 32-bit decrement and an 8-bit shift
// between the input register and the result register.
// Reset clears both stage valid flags and the parse state to expect-tag.
// When out_o stalls, the result register holds, the input register fills
// behind it, and in_i.ready drops once both are occupied; nothing is lost.
// After an error the rest of the body is marked ignored; the byte with
// body_last always returns the parser to expect-tag.
module der_tlv_stream_parser #(
  parameter int unsigned MaxLenBytes = dtp_pkg::MaxLenBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtp_in_if.sink     in_i,
  dtp_out_if.source  out_o
);

  dtp_pkg::in_item_t    item;
  dtp_pkg::out_item_t   res;
  dtp_pkg::stage_ctrl_t ctrl;
  logic                 item_valid;
  logic                 can_load;

  // Advance the held byte into the result register when there is room
  assign ctrl.valid   = item_valid;
  assign ctrl.advance = item_valid && can_load;

  dtp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (ctrl.advance),
    .item_o    (item),
    .valid_o   (item_valid)
  );

  dtp_step #(
    .MaxLenBytes (MaxLenBytes)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (ctrl.advance),
    .item_i (item),
    .res_o  (res)
  );

  dtp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  // A byte waiting on a full result register must still be held next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !can_load |=> item_valid)
    else $error("held byte dropped while result register was full");

  // Ignored bytes carry no element information
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.byte_role == dtp_pkg::ROLE_IGNORED |->
      out_o.element_end == 1'b0 && out_o.header_bytes == '0)
    else $error("ignored byte carries element fields");

  // A tag byte opens a fresh header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.byte_role == dtp_pkg::ROLE_TAG |-> out_o.header_bytes == 3'd1)
    else $error("tag byte with wrong header count");

  // element_end flags exactly the non-busy results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.element_end == (out_o.status != dtp_pkg::ST_BUSY))
    else $error("element_end disagrees with status");

endmodule
